// ===== src/itoa_pkg.sv =====
package itoa_pkg;

    localparam int CHAR_W          = 6;
    localparam int DIGIT_W         = 4;
    localparam int STEPS_PER_STAGE = 4;

    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

endpackage

// ===== src/itoa_front.sv =====
module itoa_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [VALUE_BITS-1:0] o_mag,
    output logic                  o_neg
);

    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] n_mag;
    logic                  n_neg;

    assign o_ready = !r_valid || i_ready;

    // two's complement negate; the most negative value maps to 2^(VALUE_BITS-1)
    always_comb begin
        n_neg = i_value[VALUE_BITS-1];
        n_mag = n_neg ? (~i_value + 1'b1) : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag <= n_mag;
            r_neg <= n_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule

// ===== src/itoa_dabble.sv =====
module itoa_dabble #(
    parameter int VALUE_BITS = 32,
    parameter int NDIG       = 10,
    parameter int N_STEPS    = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [VALUE_BITS-1:0]                i_bin,
    input  logic [NDIG*itoa_pkg::DIGIT_W-1:0]    i_bcd,
    input  logic                                 i_neg,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [VALUE_BITS-1:0]                o_bin,
    output logic [NDIG*itoa_pkg::DIGIT_W-1:0]    o_bcd,
    output logic                                 o_neg
);

    localparam int BCD_W = NDIG * itoa_pkg::DIGIT_W;
    localparam int DW    = itoa_pkg::DIGIT_W;

    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] n_bin;
    logic [BCD_W-1:0]      n_bcd;

    assign o_ready = !r_valid || i_ready;

    // shift-add-3 steps: adjust each digit, then shift one binary bit in
    always_comb begin
        n_bin = i_bin;
        n_bcd = i_bcd;
        for (int s = 0; s < N_STEPS; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (n_bcd[d*DW +: DW] >= 4'd5) begin
                    n_bcd[d*DW +: DW] = n_bcd[d*DW +: DW] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[VALUE_BITS-1]};
            n_bin = {n_bin[VALUE_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_bin   = r_bin;
    assign o_bcd   = r_bcd;
    assign o_neg   = r_neg;

endmodule

// ===== src/itoa_count.sv =====
module itoa_count #(
    parameter int NDIG = 10,
    parameter int IDXW = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [NDIG*itoa_pkg::DIGIT_W-1:0] i_bcd,
    input  logic                              i_neg,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [NDIG*itoa_pkg::DIGIT_W-1:0] o_bcd,
    output logic [IDXW-1:0]                   o_top,
    output logic                              o_neg
);

    localparam int BCD_W = NDIG * itoa_pkg::DIGIT_W;
    localparam int DW    = itoa_pkg::DIGIT_W;

    logic             r_valid;
    logic [BCD_W-1:0] r_bcd;
    logic [IDXW-1:0]  r_top;
    logic             r_neg;
    logic [IDXW-1:0]  n_top;

    assign o_ready = !r_valid || i_ready;

    // index of the leading nonzero digit, zero for the value zero
    always_comb begin
        n_top = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (i_bcd[d*DW +: DW] != '0) begin
                n_top = IDXW'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bcd <= i_bcd;
            r_top <= n_top;
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_bcd   = r_bcd;
    assign o_top   = r_top;
    assign o_neg   = r_neg;

endmodule

// ===== src/itoa_serial.sv =====
module itoa_serial #(
    parameter int NDIG = 10,
    parameter int IDXW = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [NDIG*itoa_pkg::DIGIT_W-1:0] i_bcd,
    input  logic [IDXW-1:0]                   i_top,
    input  logic                              i_neg,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [itoa_pkg::CHAR_W-1:0]       o_text_char,
    output logic                              o_last_char
);

    localparam int BCD_W = NDIG * itoa_pkg::DIGIT_W;
    localparam int DW    = itoa_pkg::DIGIT_W;
    localparam int CW    = itoa_pkg::CHAR_W;

    logic             r_out_valid;
    logic [CW-1:0]    r_char;
    logic             r_last;
    logic             r_busy;
    logic [IDXW-1:0]  r_idx;
    logic [BCD_W-1:0] r_bcd;

    logic             n_out_valid;
    logic [CW-1:0]    n_char;
    logic             n_last;
    logic             n_busy;
    logic [IDXW-1:0]  n_idx;
    logic [BCD_W-1:0] n_bcd;
    logic             adv;

    function automatic logic [CW-1:0] digit_char(input logic [BCD_W-1:0] bcd,
                                                 input logic [IDXW-1:0]  idx);
        logic [DW-1:0] dig;
        dig = bcd[idx*DW +: DW];
        return itoa_pkg::CH_ZERO + {{(CW-DW){1'b0}}, dig};
    endfunction

    assign adv     = !r_out_valid || i_ready;
    assign o_ready = adv && !r_busy;

    always_comb begin
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_bcd       = r_bcd;
        if (adv) begin
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_char      = digit_char(r_bcd, r_idx);
                n_last      = (r_idx == '0);
                n_busy      = (r_idx != '0);
                n_idx       = IDXW'(r_idx - 1'b1);
            end else if (i_valid) begin
                n_out_valid = 1'b1;
                n_bcd       = i_bcd;
                if (i_neg) begin
                    n_char = itoa_pkg::CH_MINUS;
                    n_last = 1'b0;
                    n_busy = 1'b1;
                    n_idx  = i_top;
                end else begin
                    n_char = digit_char(i_bcd, i_top);
                    n_last = (i_top == '0);
                    n_busy = (i_top != '0);
                    n_idx  = IDXW'(i_top - 1'b1);
                end
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_busy      <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        r_idx  <= n_idx;
        r_bcd  <= n_bcd;
    end

    assign o_valid     = r_out_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

endmodule

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_value     (VALUE_BITS, signed)
// output    o_valid / i_ready    o_text_char (6), o_last_char (1)
//
// One character leaves per cycle unless i_ready stalls the output; a number gives
// 1 to 11 characters at 32 bits. The output serializer sets that rate.
// The first character passes through the front, dabble, count and serial registers.
// i_rst_n is synchronous and clears all valid flags.
// Stalls propagate back through the ready chain; a full stage holds its data.
module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [VALUE_BITS-1:0]      i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [itoa_pkg::CHAR_W-1:0]       o_text_char,
    output logic                              o_last_char
);

    localparam int NDIG   = (VALUE_BITS * 301) / 1000 + 1;
    localparam int IDXW   = $clog2(NDIG);
    localparam int BCD_W  = NDIG * itoa_pkg::DIGIT_W;
    localparam int SPS    = itoa_pkg::STEPS_PER_STAGE;
    localparam int NSTAGE = (VALUE_BITS + SPS - 1) / SPS;

    logic                  w_valid [NSTAGE+1];
    logic                  w_rdy   [NSTAGE+1];
    logic [VALUE_BITS-1:0] w_bin   [NSTAGE+1];
    logic [BCD_W-1:0]      w_bcd   [NSTAGE+1];
    logic                  w_neg   [NSTAGE+1];

    logic                  c_valid;
    logic                  c_rdy;
    logic [BCD_W-1:0]      c_bcd;
    logic [IDXW-1:0]       c_top;
    logic                  c_neg;

    itoa_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_valid (w_valid[0]),
        .i_ready (w_rdy[0]),
        .o_mag   (w_bin[0]),
        .o_neg   (w_neg[0])
    );

    assign w_bcd[0] = '0;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_dabble
        localparam int N_STEPS = ((VALUE_BITS - g * SPS) >= SPS) ? SPS
                                                                 : (VALUE_BITS - g * SPS);
        itoa_dabble #(
            .VALUE_BITS (VALUE_BITS),
            .NDIG       (NDIG),
            .N_STEPS    (N_STEPS)
        ) u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_rdy[g]),
            .i_bin   (w_bin[g]),
            .i_bcd   (w_bcd[g]),
            .i_neg   (w_neg[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_bin   (w_bin[g+1]),
            .o_bcd   (w_bcd[g+1]),
            .o_neg   (w_neg[g+1])
        );
    end

    itoa_count #(
        .NDIG (NDIG),
        .IDXW (IDXW)
    ) u_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NSTAGE]),
        .o_ready (w_rdy[NSTAGE]),
        .i_bcd   (w_bcd[NSTAGE]),
        .i_neg   (w_neg[NSTAGE]),
        .o_valid (c_valid),
        .i_ready (c_rdy),
        .o_bcd   (c_bcd),
        .o_top   (c_top),
        .o_neg   (c_neg)
    );

    itoa_serial #(
        .NDIG (NDIG),
        .IDXW (IDXW)
    ) u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (c_valid),
        .o_ready     (c_rdy),
        .i_bcd       (c_bcd),
        .i_top       (c_top),
        .i_neg       (c_neg),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
